// ===== src/lsch_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsch_pkg
// Types and fixed constants shared by the lottery scheduler files.
// ----------------------------------------------------------------------------
package lsch_pkg;

   localparam int CMD_W     = 1;
   localparam int IDX_FW    = 3;
   localparam int TICKET_W  = 8;
   localparam int TIME_W    = 16;
   localparam int SERVICE_W = 8;
   localparam int RAND_W    = 31;
   localparam int COUNT_W   = 4;

   localparam int TICKET_MAX   = 255;
   localparam int FIN_COUNT_MAX = 15;
   localparam logic [COUNT_W-1:0] TASK_COUNT_RESET = 4'd8;
   localparam logic [TIME_W-1:0]  TICK_MAX = 16'hFFFF;

   localparam logic [CMD_W-1:0] CMD_LOAD = 1'b0;
   localparam logic [CMD_W-1:0] CMD_TICK = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_WALK_RD,
      ST_WALK_CHK,
      ST_ADM_RD,
      ST_ADM_CHK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [TICKET_W-1:0]  tickets;
      logic [TIME_W-1:0]    arrival;
      logic [SERVICE_W-1:0] service;
   } entry_type;

   typedef struct packed {
      logic              ran;
      logic [IDX_FW-1:0] chosen_task;
      logic              first_run;
      logic [TIME_W-1:0] response_time;
      logic              finished;
      logic [TIME_W-1:0] turnaround;
      logic              all_done;
      logic [TIME_W-1:0] tick_now;
   } rsp_type;

   typedef struct packed {
      logic start;
   } mod_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mod_status_type;

endpackage

// ===== src/lsch_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsch_req_if
// Request channel: load or tick commands with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lsch_req_if;
   logic                               valid;
   logic                               ready;
   logic [lsch_pkg::CMD_W-1:0]         command;
   logic [lsch_pkg::IDX_FW-1:0]        task_index;
   logic [lsch_pkg::TICKET_W-1:0]      tickets;
   logic [lsch_pkg::TIME_W-1:0]        arrival_time;
   logic [lsch_pkg::SERVICE_W-1:0]     service_time;
   logic [lsch_pkg::RAND_W-1:0]        random_value;

   modport source (
      output valid, command, task_index, tickets, arrival_time, service_time, random_value,
      input  ready
   );

   modport sink (
      input  valid, command, task_index, tickets, arrival_time, service_time, random_value,
      output ready
   );
endinterface

// ----------------------------------------------------------------------------
// lsch_rsp_if
// Response channel: one result per request with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lsch_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          ran;
   logic [lsch_pkg::IDX_FW-1:0]   chosen_task;
   logic                          first_run;
   logic [lsch_pkg::TIME_W-1:0]   response_time;
   logic                          finished;
   logic [lsch_pkg::TIME_W-1:0]   turnaround;
   logic                          all_done;
   logic [lsch_pkg::TIME_W-1:0]   tick_now;

   modport source (
      output valid, ran, chosen_task, first_run, response_time, finished, turnaround,
             all_done, tick_now,
      input  ready
   );

   modport sink (
      input  valid, ran, chosen_task, first_run, response_time, finished, turnaround,
             all_done, tick_now,
      output ready
   );
endinterface

// ===== src/lsch_mod.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsch_mod
// Bit-serial remainder unit: one dividend bit per cycle, restoring step.
// ----------------------------------------------------------------------------
module lsch_mod #(
   parameter int TOT_W = 11
) (
   input  logic                            clock,
   input  logic                            reset,
   input  lsch_pkg::mod_ctl_type           ctl,
   input  logic [lsch_pkg::RAND_W-1:0]     dividend,
   input  logic [TOT_W-1:0]                divisor,
   output lsch_pkg::mod_status_type        status,
   output logic [TOT_W-1:0]                remainder
);

   localparam int BCNT_W = $clog2(lsch_pkg::RAND_W + 1);

   logic [lsch_pkg::RAND_W-1:0] shift_ff, shift_in;
   logic [TOT_W-1:0]            rem_ff, rem_in;
   logic [TOT_W-1:0]            div_ff, div_in;
   logic [BCNT_W-1:0]           cnt_ff, cnt_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [TOT_W:0]              trial;

   always_comb begin
      shift_in = shift_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      trial    = {rem_ff, shift_ff[lsch_pkg::RAND_W-1]};
      if (ctl.start) begin
         shift_in = dividend;
         rem_in   = '0;
         div_in   = divisor;
         cnt_in   = BCNT_W'(lsch_pkg::RAND_W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so the trial fits one extra bit
         if (trial >= {1'b0, div_ff}) begin
            rem_in = TOT_W'(trial - {1'b0, div_ff});
         end else begin
            rem_in = TOT_W'(trial);
         end
         shift_in = {shift_ff[lsch_pkg::RAND_W-2:0], 1'b0};
         cnt_in   = cnt_ff - 1'b1;
         if (cnt_ff == BCNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      cnt_ff   <= cnt_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign remainder   = rem_ff;

endmodule

// ===== src/lottery_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lottery_scheduler
// Lottery scheduler over a small task table with a bit-serial ticket draw.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one request at a time: a load writes one task entry, a
//   tick runs one scheduling step. Every request gives exactly one response
//   on rsp_ch. The user must set task_count (csr_wr_en/csr_wr_data) only
//   while the block is idle; the block itself does not enforce this.
// Sequence:
//   load: the entry is written on acceptance, then ST_DONE registers the
//   response. tick: a 31-step draw reduction in the one-bit-per-cycle
//   remainder unit, a walk over the admitted entries up to the winner, the
//   admission checks (until a task not yet arrived or the task count), then
//   ST_DONE. A tick with no tickets skips the draw and the walk. Table reads
//   go through one registered read port.
// Throughput: one request in flight; the next is taken once the response
//   has been written to the output register.
// Reset: synchronous; clears tick, totals, counters, started flags, sets
//   task_count to 8 and admits task 0. Table contents are kept.
// Stall: a response waits in its register while rsp_ch.ready is low; the
//   next request is still accepted and runs, then waits to be delivered.
// ----------------------------------------------------------------------------
module lottery_scheduler #(
   parameter int TASKS = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   lsch_req_if.sink                         req_ch,
   lsch_rsp_if.source                       rsp_ch,
   input  logic                             csr_wr_en,
   input  logic [lsch_pkg::COUNT_W-1:0]     csr_wr_data
);

   localparam int IDX_W  = (TASKS > 1) ? $clog2(TASKS) : 1;
   localparam int CNT_W  = $clog2(TASKS + 1);
   localparam int ADM_MAX = (TASKS < lsch_pkg::FIN_COUNT_MAX) ? TASKS
                                                               : lsch_pkg::FIN_COUNT_MAX;
   localparam int TOT_W  = $clog2(ADM_MAX * lsch_pkg::TICKET_MAX + 1);

   lsch_pkg::state_type            state_ff, state_in;
   logic [lsch_pkg::COUNT_W-1:0]   task_count_ff;
   logic [lsch_pkg::TIME_W-1:0]    tick_ff, tick_in;
   logic [TOT_W-1:0]               total_ff, total_in;
   logic [CNT_W-1:0]               admitted_ff, admitted_in;
   logic [lsch_pkg::COUNT_W-1:0]   finished_ff, finished_in;
   logic [TASKS-1:0]               started_ff, started_in;
   logic [CNT_W-1:0]               idx_ff, idx_in;
   logic [TOT_W-1:0]               sum_ff, sum_in;
   lsch_pkg::rsp_type              res_ff, res_in;
   lsch_pkg::rsp_type              rsp_data_ff, rsp_data_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   lsch_pkg::entry_type            mem_ff [TASKS];
   lsch_pkg::entry_type            rd_data_ff;
   logic [IDX_W-1:0]               rd_addr;
   logic                           wr_en;
   logic [IDX_W-1:0]               wr_addr;
   lsch_pkg::entry_type            wr_data;

   lsch_pkg::mod_ctl_type          mod_ctl;
   lsch_pkg::mod_status_type       mod_status;
   logic [TOT_W-1:0]               draw;

   logic                           accept;
   logic [CNT_W-1:0]               limit;
   logic [TOT_W-1:0]               sum_next;
   logic [TOT_W-1:0]               rd_tickets;

   lsch_mod #(
      .TOT_W (TOT_W)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .ctl       (mod_ctl),
      .dividend  (req_ch.random_value),
      .divisor   (total_ff),
      .status    (mod_status),
      .remainder (draw)
   );

   assign req_ch.ready = (state_ff == lsch_pkg::ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign limit        = (32'(task_count_ff) < TASKS) ? CNT_W'(task_count_ff)
                                                      : CNT_W'(TASKS);
   assign rd_tickets   = TOT_W'(rd_data_ff.tickets);
   assign sum_next     = sum_ff + rd_tickets;

   always_comb begin
      state_in     = state_ff;
      tick_in      = tick_ff;
      total_in     = total_ff;
      admitted_in  = admitted_ff;
      finished_in  = finished_ff;
      started_in   = started_ff;
      idx_in       = idx_ff;
      sum_in       = sum_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in  = rsp_data_ff;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = idx_ff[IDX_W-1:0];
      wr_data      = rd_data_ff;
      mod_ctl.start = 1'b0;

      case (state_ff)
         lsch_pkg::ST_IDLE: begin
            if (accept) begin
               res_in = '0;
               if (req_ch.command == lsch_pkg::CMD_LOAD) begin
                  if (32'(req_ch.task_index) < TASKS) begin
                     wr_en           = 1'b1;
                     wr_addr         = IDX_W'(req_ch.task_index);
                     wr_data.tickets = req_ch.tickets;
                     wr_data.arrival = req_ch.arrival_time;
                     wr_data.service = req_ch.service_time;
                     started_in[IDX_W'(req_ch.task_index)] = 1'b0;
                     if (req_ch.task_index == '0) begin
                        total_in = TOT_W'(req_ch.tickets);
                     end
                  end
                  state_in = lsch_pkg::ST_DONE;
               end else begin
                  if (tick_ff != lsch_pkg::TICK_MAX) begin
                     tick_in = tick_ff + 1'b1;
                  end
                  if (total_ff != '0) begin
                     mod_ctl.start = 1'b1;
                     state_in      = lsch_pkg::ST_DIV;
                  end else begin
                     state_in = lsch_pkg::ST_ADM_RD;
                  end
               end
            end
         end

         lsch_pkg::ST_DIV: begin
            if (mod_status.done) begin
               idx_in   = '0;
               sum_in   = '0;
               state_in = lsch_pkg::ST_WALK_RD;
            end
         end

         lsch_pkg::ST_WALK_RD: begin
            rd_addr  = idx_ff[IDX_W-1:0];
            state_in = lsch_pkg::ST_WALK_CHK;
         end

         lsch_pkg::ST_WALK_CHK: begin
            if (rd_data_ff.service != '0 && draw < sum_next) begin
               res_in.ran         = 1'b1;
               res_in.chosen_task = lsch_pkg::IDX_FW'(idx_ff);
               if (!started_ff[idx_ff[IDX_W-1:0]]) begin
                  started_in[idx_ff[IDX_W-1:0]] = 1'b1;
                  res_in.first_run     = 1'b1;
                  res_in.response_time = tick_ff - rd_data_ff.arrival - 1'b1;
               end
               wr_en           = 1'b1;
               wr_data.service = rd_data_ff.service - 1'b1;
               if (rd_data_ff.service == lsch_pkg::SERVICE_W'(1)) begin
                  res_in.finished   = 1'b1;
                  res_in.turnaround = tick_ff - rd_data_ff.arrival;
                  if (32'(finished_ff) < lsch_pkg::FIN_COUNT_MAX) begin
                     finished_in = finished_ff + 1'b1;
                  end
                  // removal saturates at zero
                  if (total_ff >= rd_tickets) begin
                     total_in = total_ff - rd_tickets;
                  end else begin
                     total_in = '0;
                  end
               end
               state_in = lsch_pkg::ST_ADM_RD;
            end else begin
               // tasks with no service left keep their tickets but are skipped
               if (rd_data_ff.service != '0) begin
                  sum_in = sum_next;
               end
               if (CNT_W'(idx_ff + 1'b1) >= admitted_ff) begin
                  state_in = lsch_pkg::ST_ADM_RD;
               end else begin
                  idx_in   = CNT_W'(idx_ff + 1'b1);
                  state_in = lsch_pkg::ST_WALK_RD;
               end
            end
         end

         lsch_pkg::ST_ADM_RD: begin
            if (admitted_ff < limit) begin
               rd_addr  = admitted_ff[IDX_W-1:0];
               state_in = lsch_pkg::ST_ADM_CHK;
            end else begin
               state_in = lsch_pkg::ST_DONE;
            end
         end

         lsch_pkg::ST_ADM_CHK: begin
            // admission stops at the first task not yet arrived
            if (rd_data_ff.arrival <= tick_ff) begin
               total_in    = total_ff + rd_tickets;
               admitted_in = admitted_ff + 1'b1;
               state_in    = lsch_pkg::ST_ADM_RD;
            end else begin
               state_in = lsch_pkg::ST_DONE;
            end
         end

         lsch_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in          = res_ff;
               rsp_data_in.all_done = (finished_ff >= task_count_ff);
               rsp_data_in.tick_now = tick_ff;
               state_in             = lsch_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = lsch_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lsch_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         task_count_ff <= lsch_pkg::TASK_COUNT_RESET;
         tick_ff       <= '0;
         total_ff      <= '0;
         admitted_ff   <= CNT_W'(1);
         finished_ff   <= '0;
         started_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            task_count_ff <= csr_wr_data;
         end
         tick_ff      <= tick_in;
         total_ff     <= total_in;
         admitted_ff  <= admitted_in;
         finished_ff  <= finished_in;
         started_ff   <= started_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      sum_ff      <= sum_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // task table, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.ran           = rsp_data_ff.ran;
   assign rsp_ch.chosen_task   = rsp_data_ff.chosen_task;
   assign rsp_ch.first_run     = rsp_data_ff.first_run;
   assign rsp_ch.response_time = rsp_data_ff.response_time;
   assign rsp_ch.finished      = rsp_data_ff.finished;
   assign rsp_ch.turnaround    = rsp_data_ff.turnaround;
   assign rsp_ch.all_done      = rsp_data_ff.all_done;
   assign rsp_ch.tick_now      = rsp_data_ff.tick_now;

`ifndef ASSERT_OFF
   a_div_running: assert property (@(posedge clock) disable iff (reset)
      state_ff == lsch_pkg::ST_DIV |-> mod_status.busy || mod_status.done)
      else $error("draw reduction not running while waiting on it");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == lsch_pkg::ST_WALK_CHK |-> idx_ff < admitted_ff)
      else $error("walk went past the admitted tasks");

   a_admitted_bound: assert property (@(posedge clock) disable iff (reset)
      admitted_ff != '0 && 32'(admitted_ff) <= TASKS)
      else $error("admitted count out of range");

   a_finished_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> finished_ff >= $past(finished_ff))
      else $error("finished count went backwards");
`endif

endmodule
